/* sv/e131dmx_pkg.sv */
// Shared types, constants and header compare function for the E1.31 DMX receiver.
// Used by every module of the block; depends on nothing else.

package e131dmx_pkg;

   localparam int CHANNELS_USED = 8;
   localparam int CH_IDX_W      = (CHANNELS_USED > 1) ? $clog2(CHANNELS_USED) : 1;

   localparam int SLOT_COUNT = 512;
   localparam int SLOT_AW    = 10;
   localparam int BANK_AW    = 9;

   localparam logic [9:0] HDR_BYTES = 10'd126;
   localparam logic [9:0] MIN_LEN   = 10'd638;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   typedef enum logic [1:0] {
      FUNC_BYTE = 2'd0,
      FUNC_TICK = 2'd1,
      FUNC_READ = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      CSR_ENABLE   = 2'd0,
      CSR_UNIVERSE = 2'd1,
      CSR_START    = 2'd2,
      CSR_TIMEOUT  = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      V_ACCEPTED   = 4'd0,
      V_DISABLED   = 4'd1,
      V_SHORT      = 4'd2,
      V_IDENT      = 4'd3,
      V_ROOT_VEC   = 4'd4,
      V_FRAME_VEC  = 4'd5,
      V_UNIVERSE   = 4'd6,
      V_DMP_VEC    = 4'd7,
      V_START_CODE = 4'd8
   } verdict_type;

   localparam logic [7:0] ACN_IDENT [0:11] = '{
      8'h41, 8'h53, 8'h43, 8'h2D, 8'h45, 8'h31,
      8'h2E, 8'h31, 8'h37, 8'h00, 8'h00, 8'h00
   };

   typedef struct packed {
      logic        enabled;
      logic [15:0] universe;
      logic [9:0]  start_address;
      logic [15:0] timeout;
   } cfg_type;

   typedef struct packed {
      logic               en;
      logic [SLOT_AW-1:0] addr;
      logic [7:0]         data;
   } ram_wr_type;

   typedef struct packed {
      logic        valid;
      verdict_type code;
      logic        rx;
   } verdict_res_type;

   typedef struct packed {
      logic               valid;
      logic [SLOT_AW-1:0] addr;
      logic               zero;
      logic               last;
   } rd_issue_type;

   // Returns one mismatch bit per header check for the byte at position pos.
   function automatic logic [5:0] header_mismatch(logic [9:0] pos, logic [7:0] b,
                                                   logic [15:0] universe);
      logic [5:0] m;
      logic [3:0] idx;
      m   = '0;
      idx = 4'(pos - 10'd4);
      if (pos >= 10'd4 && pos <= 10'd15) begin
         m[0] = (b != ACN_IDENT[idx]);
      end else if (pos >= 10'd18 && pos <= 10'd21) begin
         m[1] = (b != ((pos == 10'd21) ? 8'h04 : 8'h00));
      end else if (pos >= 10'd40 && pos <= 10'd43) begin
         m[2] = (b != ((pos == 10'd43) ? 8'h02 : 8'h00));
      end else if (pos == 10'd113) begin
         m[3] = (b != universe[15:8]);
      end else if (pos == 10'd114) begin
         m[3] = (b != universe[7:0]);
      end else if (pos == 10'd117) begin
         m[4] = (b != 8'h02);
      end else if (pos == 10'd125) begin
         m[5] = (b != 8'h00);
      end
      return m;
   endfunction

endpackage

/* sv/e131dmx_slot_ram.sv */
// Two-bank slot memory, 1024 x 8, one write port and one registered read port.
// Depends on e131dmx_pkg for widths and the write port struct.

module e131dmx_slot_ram
   import e131dmx_pkg::*;
(
   input  logic               clock,
   input  ram_wr_type         wr,
   input  logic               rd_en,
   input  logic [SLOT_AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem [0:(2**SLOT_AW)-1];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/e131dmx_packet_ctrl.sv */
// Packet byte handling: position count, header checks, verdict, bank swap,
// per-bank fill counts and the packet age counter. Depends on e131dmx_pkg.

module e131dmx_packet_ctrl
   import e131dmx_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            accept_byte,
   input  logic            accept_tick,
   input  logic [7:0]      packet_byte,
   input  logic            packet_end,
   output ram_wr_type      wr,
   output verdict_res_type verdict,
   output logic            active_bank,
   output logic [9:0]      active_fill,
   output logic            receiving
);

   logic [9:0]  pos_ff, pos_in;
   logic [5:0]  flags_ff, flags_in;
   logic        bank_ff, bank_in;
   logic [15:0] age_ff, age_in;
   logic [9:0]  fill0_ff, fill0_in, fill1_ff, fill1_in;

   logic        pos_ok;
   logic [5:0]  flags_new;
   logic [9:0]  pos_new;
   logic [8:0]  wr_idx;
   logic [9:0]  wr_cnt;
   logic        wr_en;
   verdict_type code;

   always_comb begin
      pos_ok    = (pos_ff < MIN_LEN);
      flags_new = flags_ff | (pos_ok ? header_mismatch(pos_ff, packet_byte, cfg.universe)
                                     : 6'd0);
      pos_new   = pos_ok ? (pos_ff + 10'd1) : pos_ff;
      wr_idx    = 9'(pos_ff - HDR_BYTES);
      wr_cnt    = {1'b0, wr_idx} + 10'd1;
      wr_en     = accept_byte && pos_ok && (pos_ff >= HDR_BYTES);

      if (!cfg.enabled) begin
         code = V_DISABLED;
      end else if (pos_new < MIN_LEN) begin
         code = V_SHORT;
      end else if (flags_new[0]) begin
         code = V_IDENT;
      end else if (flags_new[1]) begin
         code = V_ROOT_VEC;
      end else if (flags_new[2]) begin
         code = V_FRAME_VEC;
      end else if (flags_new[3]) begin
         code = V_UNIVERSE;
      end else if (flags_new[4]) begin
         code = V_DMP_VEC;
      end else if (flags_new[5]) begin
         code = V_START_CODE;
      end else begin
         code = V_ACCEPTED;
      end

      pos_in   = pos_ff;
      flags_in = flags_ff;
      bank_in  = bank_ff;
      age_in   = age_ff;
      fill0_in = fill0_ff;
      fill1_in = fill1_ff;

      if (accept_byte) begin
         if (packet_end) begin
            pos_in   = 10'd0;
            flags_in = 6'd0;
            if (code == V_ACCEPTED) begin
               bank_in = ~bank_ff;
               age_in  = 16'd0;
            end
         end else begin
            pos_in   = pos_new;
            flags_in = flags_new;
         end
      end else if (accept_tick) begin
         if (age_ff < cfg.timeout) begin
            age_in = age_ff + 16'd1;
         end
      end

      if (wr_en) begin
         if (bank_ff) begin
            if (wr_cnt > fill0_ff) begin
               fill0_in = wr_cnt;
            end
         end else begin
            if (wr_cnt > fill1_ff) begin
               fill1_in = wr_cnt;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         flags_ff <= '0;
         bank_ff  <= 1'b0;
         age_ff   <= '0;
         fill0_ff <= '0;
         fill1_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         flags_ff <= flags_in;
         bank_ff  <= bank_in;
         age_ff   <= age_in;
         fill0_ff <= fill0_in;
         fill1_ff <= fill1_in;
      end
   end

   assign wr.en         = wr_en;
   assign wr.addr       = {~bank_ff, wr_idx};
   assign wr.data       = packet_byte;
   assign verdict.valid = accept_byte && packet_end;
   assign verdict.code  = code;
   assign verdict.rx    = (age_in < cfg.timeout);
   assign active_bank   = bank_ff;
   assign active_fill   = bank_ff ? fill1_ff : fill0_ff;
   assign receiving     = (age_ff < cfg.timeout);

endmodule

/* sv/e131dmx_read_seq.sv */
// Read sequencer: issues one window slot read per cycle while advance is high.
// Depends on e131dmx_pkg for the channel count and the issue struct.

module e131dmx_read_seq
   import e131dmx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         advance,
   input  logic [9:0]   start_address,
   input  logic         active_bank,
   input  logic [9:0]   active_fill,
   output rd_issue_type issue,
   output logic         busy
);

   logic                busy_ff, busy_in;
   logic [CH_IDX_W-1:0] idx_ff, idx_in;
   logic [CH_IDX_W-1:0] k;
   logic [9:0]          addr10;
   logic [8:0]          slot_idx;
   logic                window_ok;
   logic                last_k;

   always_comb begin
      k         = start ? '0 : idx_ff;
      addr10    = start_address + 10'(k) - 10'd1;
      slot_idx  = addr10[8:0];
      window_ok = (start_address != 10'd0) &&
                  ((11'(start_address) + 11'(CHANNELS_USED - 1)) <= 11'(SLOT_COUNT));
      last_k    = (k == CH_IDX_W'(CHANNELS_USED - 1));

      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (start) begin
         busy_in = !last_k;
         idx_in  = CH_IDX_W'(1);
      end else if (busy_ff && advance) begin
         busy_in = !last_k;
         idx_in  = idx_ff + CH_IDX_W'(1);
      end

      issue.valid = start || (busy_ff && advance);
      issue.addr  = {active_bank, slot_idx};
      issue.zero  = !window_ok || ({1'b0, slot_idx} >= active_fill);
      issue.last  = last_k;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   assign busy = busy_ff;

endmodule

/* sv/e131_dmx_packet_receiver.sv */
// Top level of the E1.31 DMX packet receiver: configuration registers, result
// stage and output register. Depends on e131dmx_pkg, e131dmx_slot_ram,
// e131dmx_packet_ctrl and e131dmx_read_seq.
//
// Items enter on the req_ channel, one packet byte, millisecond tick or
// window read each. Results leave on the rsp_ channel; both use valid/stall.
// A packet byte or tick is taken every cycle while the input does not stall
// and updates state at once. The last byte of a packet yields one verdict
// item through the result stage and the output register. A window read yields
// CHANNELS_USED channel items, one per cycle while the output does not stall;
// the input is stalled until the last slot read is issued, as the slot memory
// has a single read port. Configuration is written through the csr_ port by
// the user only while no item is in flight; the block does not enforce this.
// Reset restores the register defaults, empties the pipeline and marks both
// banks as empty through per-bank fill counts, so unwritten slots read as
// zero without a clearing pass; items are taken from the first cycle.
// When the receiver stalls, the output register holds its item; one more
// item can be taken into the result stage, and the input stalls after that.

module e131_dmx_packet_receiver
   import e131dmx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_packet_byte,
   input  logic        req_packet_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [3:0]  rsp_verdict,
   output logic [7:0]  rsp_channel_value,
   output logic        rsp_last_of_run,
   output logic        rsp_receiving,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type         cfg_ff, cfg_in;
   ram_wr_type      wr;
   verdict_res_type verdict;
   rd_issue_type    issue;
   logic            active_bank;
   logic [9:0]      active_fill;
   logic            receiving;
   logic            rd_busy;
   logic [7:0]      rd_data;

   logic            accept;
   logic            accept_byte;
   logic            accept_tick;
   logic            accept_read;

   logic            b_valid_ff, b_valid_in;
   logic            b_kind_ff;
   logic [3:0]      b_verdict_ff;
   logic            b_zero_ff;
   logic            b_last_ff;
   logic            b_rx_ff;
   logic            b_ready;

   logic            out_free;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_kind_ff;
   logic [3:0]      rsp_verdict_ff;
   logic [7:0]      rsp_value_ff;
   logic            rsp_last_ff;
   logic            rsp_rx_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_ENABLE:   cfg_in.enabled       = csr_wdata[0];
            CSR_UNIVERSE: cfg_in.universe      = csr_wdata;
            CSR_START:    cfg_in.start_address = csr_wdata[9:0];
            CSR_TIMEOUT:  cfg_in.timeout       = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled       <= 1'b1;
         cfg_ff.universe      <= 16'd1;
         cfg_ff.start_address <= 10'd1;
         cfg_ff.timeout       <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign b_ready     = !b_valid_ff || out_free;
   assign req_stall   = rd_busy || !b_ready;
   assign accept      = req_valid && !req_stall;
   assign accept_byte = accept && (req_func == FUNC_BYTE);
   assign accept_tick = accept && (req_func == FUNC_TICK);
   assign accept_read = accept && (req_func == FUNC_READ);

   e131dmx_packet_ctrl u_packet_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .accept_byte (accept_byte),
      .accept_tick (accept_tick),
      .packet_byte (req_packet_byte),
      .packet_end  (req_packet_end),
      .wr          (wr),
      .verdict     (verdict),
      .active_bank (active_bank),
      .active_fill (active_fill),
      .receiving   (receiving)
   );

   e131dmx_read_seq u_read_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (accept_read),
      .advance       (b_ready),
      .start_address (cfg_ff.start_address),
      .active_bank   (active_bank),
      .active_fill   (active_fill),
      .issue         (issue),
      .busy          (rd_busy)
   );

   e131dmx_slot_ram u_slot_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (issue.valid),
      .rd_addr (issue.addr),
      .rd_data (rd_data)
   );

   assign b_valid_in   = verdict.valid || issue.valid;
   assign rsp_valid_in = b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (b_ready) begin
            b_valid_ff <= b_valid_in;
         end
         if (out_free) begin
            rsp_valid_ff <= rsp_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready) begin
         if (issue.valid) begin
            b_kind_ff    <= 1'b1;
            b_verdict_ff <= V_ACCEPTED;
            b_zero_ff    <= issue.zero;
            b_last_ff    <= issue.last;
            b_rx_ff      <= receiving;
         end else begin
            b_kind_ff    <= 1'b0;
            b_verdict_ff <= verdict.code;
            b_zero_ff    <= 1'b1;
            b_last_ff    <= 1'b1;
            b_rx_ff      <= verdict.rx;
         end
      end
      if (out_free) begin
         rsp_kind_ff    <= b_kind_ff;
         rsp_verdict_ff <= b_verdict_ff;
         rsp_value_ff   <= b_zero_ff ? 8'd0 : rd_data;
         rsp_last_ff    <= b_last_ff;
         rsp_rx_ff      <= b_rx_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_verdict       = rsp_verdict_ff;
   assign rsp_channel_value = rsp_value_ff;
   assign rsp_last_of_run   = rsp_last_ff;
   assign rsp_receiving     = rsp_rx_ff;

   a_verdict_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_kind |-> rsp_last_of_run && (rsp_channel_value == 8'd0))
      else $error("verdict item with channel data or without end of run");

   a_channel_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind |-> (rsp_verdict == V_ACCEPTED))
      else $error("channel item carries a verdict code");

   a_read_enters_stage: assert property (@(posedge clock) disable iff (reset)
      accept_read |=> b_valid_ff && b_kind_ff)
      else $error("accepted read did not issue its first slot read");

   a_no_accept_while_reading: assert property (@(posedge clock) disable iff (reset)
      rd_busy |-> !accept)
      else $error("item accepted while a window read is in progress");

endmodule

/* tb/e131_dmx_packet_receiver_test.sv */
// Self-checking testbench for the E1.31 DMX packet receiver: random packets,
// ticks and window reads are checked against an in-bench model of the block.
// Depends on e131dmx_pkg and e131_dmx_packet_receiver.
`timescale 1ns / 1ps

module e131_dmx_packet_receiver_test;
   import e131dmx_pkg::*;

   localparam int CYCLE_LIMIT    = 16_000_000;
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 6;
   localparam int DRAIN_LIMIT    = 5000;
   localparam int PHASES         = 10;
   localparam int STEPS_PER_PHASE = 20;

   localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
   localparam logic [9:0]  SLOT_BASE     = 10'd126;
   localparam logic [9:0]  MIN_PACKET    = 10'd638;
   localparam logic [15:0] DEFAULT_TIMEOUT = 16'd1000;

   // The ACN packet identifier "ASC-E1.17" padded with three zero bytes.
   localparam logic [7:0] ACN_TEXT [12] = '{
      8'h41, 8'h53, 8'h43, 8'h2D, 8'h45, 8'h31,
      8'h2E, 8'h31, 8'h37, 8'h00, 8'h00, 8'h00
   };

   typedef enum int {
      HDR_IDENT, HDR_ROOT, HDR_FRAMING, HDR_UNIVERSE, HDR_DMP, HDR_START_CODE
   } header_field_type;

   typedef enum int {
      FAULT_NONE, FAULT_SHORT, FAULT_FIELD, FAULT_TWO_FIELDS
   } packet_fault_type;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data;
      logic       last;
   } dmx_item_type;

   typedef struct packed {
      logic        kind;
      verdict_type verdict;
      logic [7:0]  level;
      logic        last;
      logic        rx;
   } dmx_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = 2'd0;
   logic [7:0]  req_packet_byte = 8'd0;
   logic        req_packet_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_result_kind;
   logic [3:0]  rsp_verdict;
   logic [7:0]  rsp_channel_value;
   logic        rsp_last_of_run;
   logic        rsp_receiving;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_wdata = 16'd0;

   dmx_item_type   queued_items [$];
   dmx_result_type pending_dmx_results [$];

   // Model of the receiver state and its registers.
   logic [7:0]  slot_image [0:1023];
   logic        shown_bank;
   logic [9:0]  next_pos;
   logic [5:0]  fault_flags;
   logic [15:0] age_ms;
   logic        enable_cfg;
   logic [15:0] universe_cfg;
   logic [9:0]  start_cfg;
   logic [15:0] timeout_cfg;

   int  cycle_count = 0;
   int  mismatches = 0;
   int  items_taken = 0;
   int  verdicts_predicted = 0;
   int  good_packets = 0;
   int  channels_checked = 0;
   int  settings_used = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   int  hold_requests = 0;
   int  holds_done = 0;
   bit  gaps_enabled = 1'b1;
   bit  stalls_enabled = 1'b1;

   e131_dmx_packet_receiver dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_packet_byte   (req_packet_byte),
      .req_packet_end    (req_packet_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_verdict       (rsp_verdict),
      .rsp_channel_value (rsp_channel_value),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_receiving     (rsp_receiving),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // Gives the expected value and owning field of a checked header byte.
   function automatic bit header_field(input logic [9:0] pos, output logic [7:0] want,
                                       output header_field_type fld);
      want = 8'h00;
      fld = HDR_IDENT;
      header_field = 1'b1;
      if (pos >= 10'd4 && pos <= 10'd15) begin
         want = ACN_TEXT[pos - 10'd4];
      end else if (pos >= 10'd18 && pos <= 10'd21) begin
         fld = HDR_ROOT;
         want = (pos == 10'd21) ? 8'h04 : 8'h00;
      end else if (pos >= 10'd40 && pos <= 10'd43) begin
         fld = HDR_FRAMING;
         want = (pos == 10'd43) ? 8'h02 : 8'h00;
      end else if (pos == 10'd113) begin
         fld = HDR_UNIVERSE;
         want = universe_cfg[15:8];
      end else if (pos == 10'd114) begin
         fld = HDR_UNIVERSE;
         want = universe_cfg[7:0];
      end else if (pos == 10'd117) begin
         fld = HDR_DMP;
         want = 8'h02;
      end else if (pos == 10'd125) begin
         fld = HDR_START_CODE;
      end else begin
         header_field = 1'b0;
      end
   endfunction

   task automatic predict_dmx_results(input dmx_item_type it);
      logic [7:0]       want;
      header_field_type fld;
      verdict_type      code;
      dmx_result_type   res;
      int               i;
      bit               window_ok;
      case (it.func)
         FUNC_BYTE: begin
            if (next_pos < MIN_PACKET) begin
               if (header_field(next_pos, want, fld) && it.data != want) begin
                  fault_flags[fld] = 1'b1;
               end
               if (next_pos >= SLOT_BASE) begin
                  slot_image[{~shown_bank, 9'(next_pos - SLOT_BASE)}] = it.data;
               end
               next_pos = next_pos + 10'd1;
            end
            if (it.last) begin
               code = V_ACCEPTED;
               if (!enable_cfg) begin
                  code = V_DISABLED;
               end else if (next_pos < MIN_PACKET) begin
                  code = V_SHORT;
               end else begin
                  for (i = 5; i >= 0; i--) begin
                     if (fault_flags[i]) begin
                        code = verdict_type'(4'(V_IDENT) + 4'(i));
                     end
                  end
               end
               if (code == V_ACCEPTED) begin
                  shown_bank = ~shown_bank;
                  age_ms = 16'd0;
                  good_packets++;
               end
               next_pos = 10'd0;
               fault_flags = 6'd0;
               res = '{kind: 1'b0, verdict: code, level: 8'd0, last: 1'b1,
                       rx: (age_ms < timeout_cfg)};
               pending_dmx_results.push_back(res);
               verdicts_predicted++;
            end
         end
         FUNC_TICK: begin
            if (age_ms < timeout_cfg) begin
               age_ms = age_ms + 16'd1;
            end
         end
         FUNC_READ: begin
            window_ok = start_cfg != 10'd0 && int'(start_cfg) + CHANNELS_USED - 1 <= 512;
            for (i = 0; i < CHANNELS_USED; i++) begin
               res = '{kind: 1'b1, verdict: V_ACCEPTED, level: 8'd0,
                       last: (i == CHANNELS_USED - 1), rx: (age_ms < timeout_cfg)};
               if (window_ok) begin
                  res.level = slot_image[{shown_bank, 9'(int'(start_cfg) - 1 + i)}];
               end
               pending_dmx_results.push_back(res);
            end
         end
         default: begin
         end
      endcase
   endtask

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return $urandom_range(1, 2);
      end else if (r < 92) begin
         return $urandom_range(3, 8);
      end
      return $urandom_range(20, 80);
   endfunction

   // Sender: one item in flight, held while stalled, optional gap after each.
   always @(posedge clock) begin : sender
      dmx_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_dmx_results('{func: req_func, data: req_packet_byte,
                                  last: req_packet_end});
            items_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (queued_items.size() != 0) begin
               next_item = queued_items.pop_front();
               req_func <= next_item.func;
               req_packet_byte <= next_item.data;
               req_packet_end <= next_item.last;
               req_valid <= 1'b1;
               gap_left = (gaps_enabled && $urandom_range(0, 3) == 0) ? gap_length() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: rsp_%s expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Receiver: checks each accepted result, stalls at random and on request.
   always @(posedge clock) begin : receiver
      dmx_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_dmx_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual kind %0d value %0d",
                        $time, rsp_result_kind, rsp_channel_value);
            end else begin
               want = pending_dmx_results.pop_front();
               compare_field("result_kind", want.kind, rsp_result_kind);
               compare_field("verdict", want.verdict, rsp_verdict);
               compare_field("channel_value", want.level, rsp_channel_value);
               compare_field("last_of_run", want.last, rsp_last_of_run);
               compare_field("receiving", want.rx, rsp_receiving);
               if (want.kind) begin
                  channels_checked++;
               end
            end
         end
         if (hold_requests > holds_done) begin
            holds_done++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (stalls_enabled && $urandom_range(0, 3) == 0) begin
            stall_left = gap_length() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic queue_item(input logic [1:0] func, input logic [7:0] data, input logic last);
      queued_items.push_back('{func: func, data: data, last: last});
   endtask

   function automatic int fault_position(input header_field_type fld);
      case (fld)
         HDR_IDENT:    return $urandom_range(4, 15);
         HDR_ROOT:     return $urandom_range(18, 21);
         HDR_FRAMING:  return $urandom_range(40, 43);
         HDR_UNIVERSE: return $urandom_range(0, 1) ? 113 : 114;
         HDR_DMP:      return 117;
         default:      return 125;
      endcase
   endfunction

   // Builds a packet for the current universe, breaks it as asked, and
   // now and then slips a tick or a read in between its bytes.
   task automatic queue_packet(input packet_fault_type fault, input int length);
      logic [7:0]       bytes_out [];
      logic [7:0]       want;
      header_field_type fld;
      int               pos;
      int               n;
      bytes_out = new[length];
      for (pos = 0; pos < length; pos++) begin
         if (header_field(10'(pos), want, fld) && pos < int'(MIN_PACKET)) begin
            bytes_out[pos] = want;
         end else begin
            bytes_out[pos] = 8'($urandom());
         end
      end
      if (fault == FAULT_FIELD || fault == FAULT_TWO_FIELDS) begin
         for (n = 0; n < ((fault == FAULT_TWO_FIELDS) ? 2 : 1); n++) begin
            pos = fault_position(header_field_type'($urandom_range(0, 5)));
            bytes_out[pos] = bytes_out[pos] ^ 8'($urandom_range(1, 255));
         end
      end
      for (pos = 0; pos < length; pos++) begin
         if ($urandom_range(0, 299) == 0) begin
            queue_item($urandom_range(0, 1) ? FUNC_TICK : FUNC_READ, 8'($urandom()),
                       1'($urandom()));
         end
         queue_item(FUNC_BYTE, bytes_out[pos], pos == length - 1);
      end
   endtask

   task automatic random_step();
      int               r;
      int               n;
      int               i;
      packet_fault_type fault;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: fault = FAULT_NONE;
            5:             fault = FAULT_SHORT;
            6, 7, 8:       fault = FAULT_FIELD;
            default:       fault = FAULT_TWO_FIELDS;
         endcase
         if (fault == FAULT_SHORT) begin
            n = $urandom_range(0, 1) ? $urandom_range(1, 125) : $urandom_range(126, 637);
         end else begin
            n = int'(MIN_PACKET) + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0);
         end
         queue_packet(fault, n);
      end else if (r < 40) begin
         repeat ($urandom_range(1, 12)) queue_item(FUNC_TICK, 8'($urandom()), 1'($urandom()));
      end else if (r < 70) begin
         repeat ($urandom_range(1, 3)) queue_item(FUNC_READ, 8'($urandom()), 1'($urandom()));
      end else if (r < 85) begin
         n = $urandom_range(1, 20);
         for (i = 0; i < n; i++) begin
            queue_item(FUNC_BYTE, 8'($urandom()), i == n - 1);
         end
      end else if (r < 92) begin
         repeat ($urandom_range(1, 3)) queue_item(FUNC_UNUSED, 8'($urandom()), 1'($urandom()));
      end else begin
         queue_item(FUNC_TICK, 8'd0, 1'b0);
         queue_item(FUNC_READ, 8'd0, 1'b0);
      end
   endtask

   task automatic write_setting(input csr_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_ENABLE:   enable_cfg = value[0];
         CSR_UNIVERSE: universe_cfg = value;
         CSR_START:    start_cfg = value[9:0];
         default:      timeout_cfg = value;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (queued_items.size() != 0 || req_valid || pending_dmx_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      int          ph;
      int          step;
      int          drain;
      logic        en;
      logic [15:0] univ;
      logic [15:0] start;
      logic [15:0] tmo;

      for (int i = 0; i < 1024; i++) begin
         slot_image[i] = 8'd0;
      end
      shown_bank = 1'b0;
      next_pos = 10'd0;
      fault_flags = 6'd0;
      age_ms = 16'd0;
      enable_cfg = 1'b1;
      universe_cfg = 16'd1;
      start_cfg = 10'd1;
      timeout_cfg = DEFAULT_TIMEOUT;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed items at the reset settings.
      queue_item(FUNC_READ, 8'h00, 1'b0);
      queue_item(FUNC_UNUSED, 8'hFF, 1'b1);
      queue_item(FUNC_TICK, 8'hFF, 1'b1);
      queue_item(FUNC_BYTE, 8'h00, 1'b1);
      queue_item(FUNC_BYTE, 8'hFF, 1'b0);
      queue_item(FUNC_BYTE, 8'h80, 1'b1);
      queue_item(FUNC_READ, 8'hFF, 1'b1);
      queue_packet(FAULT_NONE, int'(MIN_PACKET));
      queue_item(FUNC_READ, 8'h00, 1'b0);
      queue_packet(FAULT_NONE, int'(MIN_PACKET) + 5);
      queue_item(FUNC_READ, 8'h00, 1'b0);
      wait_idle();

      // The receiver holds off while reads keep coming, so the input backs up.
      gaps_enabled = 1'b0;
      stalls_enabled = 1'b0;
      repeat (30) queue_item(FUNC_READ, 8'($urandom()), 1'b0);
      hold_requests++;
      wait_idle();

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               en = 1'b1; univ = 16'd63999; start = 16'd505; tmo = 16'd65535;
            end
            1: begin
               en = 1'b0; univ = 16'd1; start = 16'd512; tmo = 16'd0;
            end
            2: begin
               en = 1'b1; univ = 16'd7; start = 16'd0; tmo = 16'd3;
            end
            3: begin
               en = 1'b1; univ = 16'd1000; start = 16'd506; tmo = 16'd40;
            end
            4: begin
               en = 1'b1; univ = 16'($urandom_range(1, 63999)); start = 16'd1; tmo = 16'd5;
            end
            default: begin
               en = ($urandom_range(0, 5) != 0);
               univ = 16'($urandom_range(1, 63999));
               start = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 512))
                                                    : 16'($urandom_range(1, 505));
               tmo = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                  : 16'($urandom_range(0, 60));
            end
         endcase
         write_setting(CSR_ENABLE, {15'd0, en});
         write_setting(CSR_UNIVERSE, univ);
         write_setting(CSR_START, start);
         write_setting(CSR_TIMEOUT, tmo);
         settings_used++;
         gaps_enabled = (ph % 3 != 1);
         stalls_enabled = (ph % 3 != 2);

         queue_packet(FAULT_NONE, int'(MIN_PACKET));
         queue_item(FUNC_READ, 8'h00, 1'b0);
         for (step = 0; step < STEPS_PER_PHASE; step++) begin
            random_step();
         end
         // Let the age saturate so that the next, lower timeout falls below it.
         if (ph == 3) begin
            repeat (50) queue_item(FUNC_TICK, 8'($urandom()), 1'($urandom()));
         end
         wait_idle();
      end

      drain = 0;
      while (pending_dmx_results.size() != 0 && drain < DRAIN_LIMIT) begin
         @(negedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_dmx_results.size() != 0) begin
         mismatches++;
         $display("%0t: %0d expected results, actual none", $time, pending_dmx_results.size());
      end

      $display("Checked %0d items over %0d register settings: %0d verdicts (%0d accepted),",
               items_taken, settings_used, verdicts_predicted, good_packets);
      $display("%0d channel values, one long receiver hold; %0d mismatches.",
               channels_checked, mismatches);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
sv/e131dmx_pkg.sv
sv/e131dmx_slot_ram.sv
sv/e131dmx_packet_ctrl.sv
sv/e131dmx_read_seq.sv
sv/e131_dmx_packet_receiver.sv
tb/e131_dmx_packet_receiver_test.sv
